[src/cpn_pkg.sv]
// Shared types and constants for the complex phase normalizer.
// Used by every module of the block; depends on nothing else.

package cpn_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int OUT_WIDTH = 16;
   localparam int MAG_WIDTH = 15;

   localparam int REQ_DATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * OUT_WIDTH + 7) / 8) * 8;

   // The vectoring path works on the input scaled by 2^(58-SAMPLE_WIDTH), so full scale
   // sits near bit 57. Its magnitude stays below 2.4 input full scales, under 2^59.
   localparam int VEC_SHIFT = 58 - SAMPLE_WIDTH;
   localparam int VEC_W     = SAMPLE_WIDTH + VEC_SHIFT + 2;
   // The rotation path is Q32 and stays below 2^48.
   localparam int FRAC_W  = 32;
   localparam int ROT_W   = 50;
   localparam int SHIFT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
   localparam int RES_W   = ROT_W - FRAC_W;

   localparam int PROD_W = MAG_WIDTH + FRAC_W;

   // Reciprocal of the CORDIC gain in Q32.
   localparam logic [FRAC_W-1:0] INV_GAIN_Q32 = 32'h9B74EDA8;
   localparam logic [MAG_WIDTH-1:0] MAG_RESET = 15'h7FFF;

   localparam logic signed [ROT_W-1:0] ROUND_HALF = {{(ROT_W - FRAC_W){1'b0}}, 1'b1,
                                                     {(FRAC_W - 1){1'b0}}};
   localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(32767);
   localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(32767);

   // Quarter turn applied before the iterations, undone after them.
   typedef enum logic [1:0] {
      QUAD_NONE,
      QUAD_POS,   // turned by -90 degrees, restored by +90 degrees
      QUAD_NEG    // turned by +90 degrees, restored by -90 degrees
   } quad_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [ROT_W-1:0] rx;
      logic signed [ROT_W-1:0] ry;
      quad_type                quad;
      logic                    zero;
   } item_type;

endpackage

[src/cpn_entry.sv]
// Entry stage of the complex phase normalizer: quadrant turn and scaling of the input,
// start value of the rotation vector. Depends on cpn_pkg.

module cpn_entry import cpn_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] re,
   input  logic signed [SAMPLE_WIDTH-1:0] im,
   input  logic [MAG_WIDTH-1:0]           magnitude,
   output logic                           out_valid,
   input  logic                           out_ready,
   output item_type                       out_item
);

   logic              valid_ff, valid_in;
   item_type          item_ff, item_in;
   logic signed [VEC_W-1:0] sx, sy;
   logic [PROD_W-1:0] prod;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sx   = VEC_W'(re) <<< VEC_SHIFT;
      sy   = VEC_W'(im) <<< VEC_SHIFT;
      prod = PROD_W'(magnitude) * PROD_W'(INV_GAIN_Q32);
      item_in.rx   = $signed(ROT_W'(prod));
      item_in.ry   = '0;
      item_in.zero = (re == '0) && (im == '0);
      if (!re[SAMPLE_WIDTH-1]) begin
         item_in.vx   = sx;
         item_in.vy   = sy;
         item_in.quad = QUAD_NONE;
      end else if (!im[SAMPLE_WIDTH-1]) begin
         item_in.vx   = sy;
         item_in.vy   = -sx;
         item_in.quad = QUAD_POS;
      end else begin
         item_in.vx   = -sy;
         item_in.vy   = sx;
         item_in.quad = QUAD_NEG;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[src/cpn_cell.sv]
// One CORDIC iteration: a vectoring step on the input vector whose direction also drives
// the opposite rotation step on the output vector. Depends on cpn_pkg.

module cpn_cell import cpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [SHIFT_W-1:0] stage_idx,
   input  logic               in_valid,
   output logic               in_ready,
   input  item_type           in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output item_type           out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic signed [VEC_W-1:0] vx, vy, vdx, vdy;
   logic signed [ROT_W-1:0] rx, ry, rdx, rdy;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      vx  = in_item.vx;
      vy  = in_item.vy;
      rx  = in_item.rx;
      ry  = in_item.ry;
      vdx = vy >>> stage_idx;
      vdy = vx >>> stage_idx;
      rdx = ry >>> stage_idx;
      rdy = rx >>> stage_idx;
      item_in = in_item;
      // A non-negative y turns the input clockwise and the output counterclockwise.
      if (!vy[VEC_W-1]) begin
         item_in.vx = vx + vdx;
         item_in.vy = vy - vdy;
         item_in.rx = rx - rdx;
         item_in.ry = ry + rdy;
      end else begin
         item_in.vx = vx - vdx;
         item_in.vy = vy + vdy;
         item_in.rx = rx + rdx;
         item_in.ry = ry - rdy;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[src/cpn_exit.sv]
// Exit stage of the complex phase normalizer: undoes the quadrant turn, rounds the Q32
// result, saturates it and holds it for the response channel. Depends on cpn_pkg.

module cpn_exit import cpn_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  item_type                    in_item,
   input  logic [MAG_WIDTH-1:0]        magnitude,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [OUT_WIDTH-1:0] re_out,
   output logic signed [OUT_WIDTH-1:0] im_out
);

   logic                        valid_ff, valid_in;
   logic signed [OUT_WIDTH-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [ROT_W-1:0]     qx, qy, sum_x, sum_y;
   logic signed [RES_W-1:0]     res_x, res_y;

   function automatic logic signed [OUT_WIDTH-1:0] clamp(input logic signed [RES_W-1:0] v);
      logic signed [RES_W-1:0] c;
      if (v > OUT_MAX) begin
         c = OUT_MAX;
      end else if (v < OUT_MIN) begin
         c = OUT_MIN;
      end else begin
         c = v;
      end
      return OUT_WIDTH'(c);
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      case (in_item.quad)
         QUAD_POS: begin
            qx = -in_item.ry;
            qy = in_item.rx;
         end
         QUAD_NEG: begin
            qx = in_item.ry;
            qy = -in_item.rx;
         end
         default: begin
            qx = in_item.rx;
            qy = in_item.ry;
         end
      endcase
      // Round half up, then keep the integer part.
      sum_x = qx + ROUND_HALF;
      sum_y = qy + ROUND_HALF;
      res_x = sum_x[ROT_W-1:FRAC_W];
      res_y = sum_y[ROT_W-1:FRAC_W];
      if (in_item.zero) begin
         re_in = $signed(OUT_WIDTH'(magnitude));
         im_in = '0;
      end else begin
         re_in = clamp(res_x);
         im_in = clamp(res_y);
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign out_valid = valid_ff;
   assign re_out    = re_ff;
   assign im_out    = im_ff;

endmodule

[src/complex_phase_normalizer.sv]
// Complex phase normalizer: replaces the magnitude of each complex sample by a set value
// while keeping its phase. Depends on cpn_pkg, cpn_entry, cpn_cell and cpn_exit.

// Each request carries one complex sample and gives exactly one response, in order, with
// the same phase and the magnitude held in the target register, rounded and clamped to
// +/-32767; a zero sample gives (target, 0). The block takes one request every clock cycle
// while the response side does not stall it, and passes through CORDIC_STAGES + 2 registers:
// an entry stage, one cell per CORDIC iteration and an output stage. Every stage holds its
// item only while the next one is full, so gaps close up under back pressure. The target
// register is written with csr_wr_en and should change only while no request is in flight.

module complex_phase_normalizer import cpn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // re_in, im_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // re_out, im_out
   input  logic                  csr_wr_en,
   input  logic [MAG_WIDTH-1:0]  csr_wr_data  // target_magnitude
);

   logic [MAG_WIDTH-1:0] target_magnitude_ff, target_magnitude_in;

   logic     stage_valid [CORDIC_STAGES+1];
   logic     stage_ready [CORDIC_STAGES+1];
   item_type stage_item  [CORDIC_STAGES+1];

   logic signed [OUT_WIDTH-1:0] re_out, im_out;

   assign target_magnitude_in = csr_wr_en ? csr_wr_data : target_magnitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_magnitude_ff <= MAG_RESET;
      end else begin
         target_magnitude_ff <= target_magnitude_in;
      end
   end

   cpn_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .re        (req_tdata[SAMPLE_WIDTH-1:0]),
      .im        (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .magnitude (target_magnitude_ff),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_item  (stage_item[0])
   );

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      cpn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (SHIFT_W'(k)),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_item   (stage_item[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_item  (stage_item[k+1])
      );
   end

   cpn_exit u_exit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[CORDIC_STAGES]),
      .in_ready  (stage_ready[CORDIC_STAGES]),
      .in_item   (stage_item[CORDIC_STAGES]),
      .magnitude (target_magnitude_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .re_out    (re_out),
      .im_out    (im_out)
   );

   assign rsp_tdata = RSP_DATA_W'({im_out, re_out});

   // A free response side leaves every stage free to move.
   assert property (@(posedge clock) disable iff (reset) rsp_tready |-> req_tready)
      else $error("request side stalled while the response side is ready");

   // The clamp never lets the most negative code through.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[OUT_WIDTH-1:0] != 16'h8000 &&
                      rsp_tdata[2*OUT_WIDTH-1:OUT_WIDTH] != 16'h8000))
      else $error("response outside the saturation range");

   // No response appears in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule
